// ----- hw/rtl/nms_pkg.sv -----
// nms_pkg: types and constants shared by the neighbour mean stencil
// used by nms_nbr_sum and neighbour_mean_stencil; no dependencies

package nms_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_W  = 16;
    localparam int ROW_W     = 16;
    localparam int COLS_W    = 11;
    localparam int OUT_COL_W = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // neighbour sum of up to eight samples, and its magnitude
    localparam int SUM_W = SAMPLE_W + 3;
    localparam int MAG_W = SUM_W;

    // reciprocal constants for divide by 3 and by 5, exact for MAG_W-bit magnitudes
    localparam int DIV_SHIFT = 21;
    localparam int RECIP_W   = 20;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2**DIV_SHIFT + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((2**DIV_SHIFT + 4) / 5);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    // results one sample can cause, in delivery order
    localparam int JOB_COUNT = 4;

    typedef enum logic [1:0] {
        JOB_UP_PREV  = 2'd0,  // row above, previous column
        JOB_UP_LAST  = 2'd1,  // row above, last column
        JOB_CUR_PREV = 2'd2,  // last row, previous column
        JOB_CUR_LAST = 2'd3   // last row, last column
    } t_job_kind;

    typedef enum logic [1:0] {
        DIV_BY_3 = 2'd0,
        DIV_BY_5 = 2'd1,
        DIV_BY_8 = 2'd2
    } t_div;

    // 3x3 window, [row][col], row 2 and col 2 newest
    typedef logic [2:0][2:0][SAMPLE_W-1:0] t_window;

    typedef struct packed {
        t_job_kind kind;
        logic      up;    // row above the centre exists
        logic      left;  // column left of the centre exists
    } t_job;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        t_div             div;
    } t_sum;

endpackage

// ----- hw/rtl/nms_nbr_sum.sv -----
// nms_nbr_sum: sum of the existing neighbours of one window cell, as sign and magnitude
// depends on nms_pkg

module nms_nbr_sum
    import nms_pkg::*;
(
    input  t_window i_win,
    input  t_job    i_job,
    output t_sum    o_sum
);

    logic [8:0]              incl;
    logic signed [SUM_W-1:0] acc;

    // centre cell, neighbour mask and signed sum
    always_comb begin
        int cr;
        int cc;
        cr = (i_job.kind inside {JOB_CUR_PREV, JOB_CUR_LAST}) ? 2 : 1;
        cc = (i_job.kind inside {JOB_UP_LAST, JOB_CUR_LAST}) ? 2 : 1;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                incl[i*3+j] = (i + 1 >= cr) && (j + 1 >= cc)
                              && !(i == cr && j == cc)
                              && (i != cr - 1 || i_job.up)
                              && (j != cc - 1 || i_job.left);
                if (incl[i*3+j]) begin
                    acc = acc + SUM_W'(signed'(i_win[i][j]));
                end
            end
        end
    end

    // divisor from neighbour count, sign and magnitude for the divider
    always_comb begin
        case ($countones(incl))
            8:       o_sum.div = DIV_BY_8;
            5:       o_sum.div = DIV_BY_5;
            default: o_sum.div = DIV_BY_3;
        endcase
        o_sum.neg = acc[SUM_W-1];
        o_sum.mag = acc[SUM_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
    end

endmodule

// ----- hw/rtl/neighbour_mean_stencil.sv -----
// neighbour_mean_stencil: 3x3 neighbour mean, centre excluded, over a raster frame
// depends on nms_pkg and nms_nbr_sum
//
// channel   direction  handshake                fields
// input     in         i_in_valid / o_in_stall  i_sample
// output    out        o_out_valid / i_out_stall o_mean_value o_out_row o_out_col
//                                               o_last_of_run o_frame_done
// config    in         i_cfg_we (write only)    i_cfg_idx i_cfg_data
//
// one sample per cycle while each causes at most one result and the output is not stalled;
// the result issue stage sends one mean per cycle while the output is not stalled, so a
// middle row's last column and every column after the first in the last row (two results
// each) and the last row's last column (four results) hold off the next sample until issued
// after its request is accepted, a result passes the line store read, window, neighbour
// sum and output registers; the divide feeds the output register
// reset is synchronous; line stores are not cleared
// i_out_stall holds the output register and backs up to o_in_stall in the same cycle

module neighbour_mean_stencil
    import nms_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data,
    // sample requests
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // result requests
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SAMPLE_W-1:0]   o_mean_value,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [OUT_COL_W-1:0]  o_out_col,
    output logic                  o_last_of_run,
    output logic                  o_frame_done
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int CW     = (ADDR_W + 1 > COLS_W) ? ADDR_W + 1 : COLS_W;

    // configuration and position
    logic [ROW_W-1:0]  r_row_count;
    logic [COLS_W-1:0] r_col_count;
    logic [ROW_W-1:0]  r_row_pos;
    logic [ADDR_W-1:0] r_col_pos;

    // line stores
    logic [SAMPLE_W-1:0] r_older_line  [MAX_COLS];
    logic [SAMPLE_W-1:0] r_recent_line [MAX_COLS];
    logic [SAMPLE_W-1:0] r_old_q;
    logic [SAMPLE_W-1:0] r_rec_q;

    // stage 1: sample and its position
    logic                r_p1_vld;
    logic [SAMPLE_W-1:0] r_p1_sample;
    logic [ROW_W-1:0]    r_p1_row;
    logic [ADDR_W-1:0]   r_p1_addr;
    logic                r_p1_last_col;
    logic                r_p1_last_row;

    // stage 2: window and pending results
    t_window              r_win;
    logic [JOB_COUNT-1:0] r_p2_mask;
    logic [ROW_W-1:0]     r_p2_row;
    logic [ADDR_W-1:0]    r_p2_col;

    // stage 3: neighbour sum
    logic                 r_p3_vld;
    t_sum                 r_p3_sum;
    logic [ROW_W-1:0]     r_p3_row;
    logic [OUT_COL_W-1:0] r_p3_col;
    logic                 r_p3_last;
    logic                 r_p3_fdone;

    // output register
    logic                 r_out_vld;
    logic [SAMPLE_W-1:0]  r_out_mean;
    logic [ROW_W-1:0]     r_out_row;
    logic [OUT_COL_W-1:0] r_out_col;
    logic                 r_out_last;
    logic                 r_out_fdone;

    logic in_acc, p1_adv, p1_free, p2_busy, p2_issue, p2_free, p3_free, p3_adv, out_free;
    logic run_end;
    logic [CW-1:0]        cols_cfg, cols_eff;
    logic [ROW_W-1:0]     rows_eff;
    logic                 last_col, last_row;
    logic [JOB_COUNT-1:0] n_p2_mask, rem_mask;
    t_job                 job;
    t_sum                 job_sum;
    logic [ROW_W-1:0]     job_row;
    logic [OUT_COL_W-1:0] job_col;
    logic [PROD_W-1:0]    prod;
    logic [MAG_W-1:0]     quot;
    logic [SAMPLE_W-1:0]  n_out_mean;

    // flow control, back to front
    assign out_free   = !r_out_vld || !i_out_stall;
    assign p3_free    = !r_p3_vld || out_free;
    assign p3_adv     = r_p3_vld && out_free;
    assign p2_busy    = |r_p2_mask;
    assign p2_issue   = p2_busy && p3_free;
    assign p2_free    = !p2_busy || (p2_issue && run_end);
    assign p1_adv     = r_p1_vld && p2_free;
    assign p1_free    = !r_p1_vld || p2_free;
    assign o_in_stall = !p1_free;
    assign in_acc     = i_in_valid && p1_free;

    // effective frame size
    always_comb begin
        cols_cfg = CW'(r_col_count);
        cols_eff = cols_cfg;
        if (cols_cfg < CW'(2)) begin
            cols_eff = CW'(2);
        end else if (cols_cfg > CW'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end
        rows_eff = (r_row_count < ROW_W'(2)) ? ROW_W'(2) : r_row_count;
        last_col = CW'(CW'(r_col_pos) + CW'(1)) >= cols_eff;
        last_row = r_row_pos >= ROW_W'(rows_eff - ROW_W'(1));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_W'(2);
            r_col_count <= COLS_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROW_W-1:0];
                CFG_COL_COUNT: r_col_count <= i_cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col_pos <= '0;
                r_row_pos <= last_row ? '0 : ROW_W'(r_row_pos + ROW_W'(1));
            end else begin
                r_col_pos <= ADDR_W'(r_col_pos + ADDR_W'(1));
            end
        end
    end

    // line stores: read on request, rotate when the column enters the window
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old_q <= r_older_line[r_col_pos];
            r_rec_q <= r_recent_line[r_col_pos];
        end
        if (p1_adv) begin
            r_older_line[r_p1_addr]  <= r_rec_q;
            r_recent_line[r_p1_addr] <= r_p1_sample;
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (in_acc) begin
            r_p1_vld <= 1'b1;
        end else if (p1_adv) begin
            r_p1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_sample   <= i_sample;
            r_p1_row      <= r_row_pos;
            r_p1_addr     <= r_col_pos;
            r_p1_last_col <= last_col;
            r_p1_last_row <= last_row;
        end
    end

    // results caused by the stage 1 sample
    always_comb begin
        n_p2_mask = '0;
        if (r_p1_row != '0) begin
            n_p2_mask[JOB_UP_PREV]  = (r_p1_addr != '0);
            n_p2_mask[JOB_UP_LAST]  = r_p1_last_col;
            n_p2_mask[JOB_CUR_PREV] = r_p1_last_row && (r_p1_addr != '0);
            n_p2_mask[JOB_CUR_LAST] = r_p1_last_row && r_p1_last_col;
        end
    end

    // pick the next pending result in order
    always_comb begin
        if (r_p2_mask[JOB_UP_PREV]) begin
            job.kind = JOB_UP_PREV;
        end else if (r_p2_mask[JOB_UP_LAST]) begin
            job.kind = JOB_UP_LAST;
        end else if (r_p2_mask[JOB_CUR_PREV]) begin
            job.kind = JOB_CUR_PREV;
        end else begin
            job.kind = JOB_CUR_LAST;
        end
        rem_mask           = r_p2_mask;
        rem_mask[job.kind] = 1'b0;
        run_end            = (rem_mask == '0);
        job.up   = (job.kind inside {JOB_CUR_PREV, JOB_CUR_LAST}) || (r_p2_row > ROW_W'(1));
        job.left = (job.kind inside {JOB_UP_LAST, JOB_CUR_LAST}) || (r_p2_col > ADDR_W'(1));
        job_row  = (job.kind inside {JOB_UP_PREV, JOB_UP_LAST})
                   ? ROW_W'(r_p2_row - ROW_W'(1)) : r_p2_row;
        job_col  = (job.kind inside {JOB_UP_PREV, JOB_CUR_PREV})
                   ? OUT_COL_W'(ADDR_W'(r_p2_col - ADDR_W'(1))) : OUT_COL_W'(r_p2_col);
    end

    // window shift and pending results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_p2_mask <= '0;
        end else if (p1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_old_q;
            r_win[1][2] <= r_rec_q;
            r_win[2][2] <= r_p1_sample;
            r_p2_mask   <= n_p2_mask;
        end else if (p2_issue) begin
            r_p2_mask <= rem_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_adv) begin
            r_p2_row <= r_p1_row;
            r_p2_col <= r_p1_addr;
        end
    end

    // neighbour sum of the selected cell
    nms_nbr_sum u_nbr_sum (
        .i_win (r_win),
        .i_job (job),
        .o_sum (job_sum)
    );

    // stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (p2_issue) begin
            r_p3_vld <= 1'b1;
        end else if (p3_adv) begin
            r_p3_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p2_issue) begin
            r_p3_sum   <= job_sum;
            r_p3_row   <= job_row;
            r_p3_col   <= job_col;
            r_p3_last  <= run_end;
            r_p3_fdone <= (job.kind == JOB_CUR_LAST);
        end
    end

    // divide magnitude by the neighbour count, truncating toward zero
    always_comb begin
        prod = '0;
        case (r_p3_sum.div)
            DIV_BY_3: begin
                prod = PROD_W'(r_p3_sum.mag) * PROD_W'(RECIP_3);
                quot = MAG_W'(prod >> DIV_SHIFT);
            end
            DIV_BY_5: begin
                prod = PROD_W'(r_p3_sum.mag) * PROD_W'(RECIP_5);
                quot = MAG_W'(prod >> DIV_SHIFT);
            end
            DIV_BY_8: quot = r_p3_sum.mag >> 3;
            default:  quot = '0;
        endcase
        n_out_mean = r_p3_sum.neg ? SAMPLE_W'(MAG_W'('0) - quot) : SAMPLE_W'(quot);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (p3_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p3_adv) begin
            r_out_mean  <= n_out_mean;
            r_out_row   <= r_p3_row;
            r_out_col   <= r_p3_col;
            r_out_last  <= r_p3_last;
            r_out_fdone <= r_p3_fdone;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_mean_value  = r_out_mean;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_last_of_run = r_out_last;
    assign o_frame_done  = r_out_fdone;

    // the line store write and a new read never hit the same column
    a_no_store_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p1_adv && in_acc) |-> (r_p1_addr != r_col_pos))
        else $error("line store read and write at the same column");

    // results are only pending for samples below the top row
    a_pending_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_p2_mask) |-> (r_p2_row != '0))
        else $error("results pending for a top row sample");

    // an unfinished run keeps the issue stage busy
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p2_issue && !run_end && !p1_adv) |=> p2_busy)
        else $error("pending results lost mid run");

    // the end of a frame closes the run of its request
    a_frame_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame end without end of run");

endmodule
